@@ design/motion_variance_state_detector_assert.svh @@
// Assertion macros shared by the checker of the motion variance state detector.
// Depends on nothing; included by the checker file.
`ifndef MOTION_VARIANCE_STATE_DETECTOR_ASSERT_SVH
`define MOTION_VARIANCE_STATE_DETECTOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MVSD_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mvsd assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define MVSD_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mvsd assertion failed");

// Next-cycle implication that stays armed during reset.
`define MVSD_ASSERT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mvsd assertion failed");

`endif

@@ design/mvsd_pkg.sv @@
// Shared types and constants of the motion variance state detector.
// Depends on nothing; imported by the top level and the back end.
package mvsd_pkg;

  localparam int THR_W       = 31;
  localparam int HYST_W      = 8;
  localparam int RUN_W       = HYST_W + 1;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [THR_W-1:0]  THR_RESET  = 31'd4096;
  localparam logic [HYST_W-1:0] HYST_RESET = 8'd10;

  typedef enum logic {
    REG_MOTION_THRESHOLD = 1'b0,
    REG_HYSTERESIS_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]  motion_threshold;
    logic [HYST_W-1:0] hysteresis_count;
  } cfg_t;

endpackage

@@ design/mvsd_ifs.sv @@
// Valid/ready stream interfaces for the sample input and the result output.
// Depends on nothing.
interface mvsd_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;

  modport source (output valid, accel_x, accel_y, input ready);
  modport sink   (input valid, accel_x, accel_y, output ready);
endinterface

interface mvsd_out_if ();
  logic valid;
  logic ready;
  logic flying;
  logic above_threshold;

  modport source (output valid, flying, above_threshold, input ready);
  modport sink   (input valid, flying, above_threshold, output ready);
endinterface

@@ design/mvsd_fifo.sv @@
// Short show-ahead queue between the front end and the back end.
// Depends on nothing.
module mvsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               push_data,
  input  logic                           pop,
  output logic [WIDTH-1:0]               pop_data,
  output logic                           not_empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign pop_data  = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/mvsd_front.sv @@
// Front end: sample windows in memory, running sums and sums of squares.
// Depends on nothing; feeds the queue in front of the back end.
module mvsd_front #(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 22,
  parameter int SQ_W        = 37
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic signed [SAMPLE_BITS-1:0]     accel_x,
  input  logic signed [SAMPLE_BITS-1:0]     accel_y,
  output logic [1:0]                        busy,
  output logic                              push,
  output logic [2*(SUM_W+SQ_W)-1:0]         push_data
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int SB    = SAMPLE_BITS;

  logic [2*SB-1:0]        win_mem [WINDOW];
  logic [PTR_W-1:0]       ptr_r;
  logic                   filled_r;
  logic                   f1_v_r, f2_v_r;

  logic [2*SB-1:0]        old_r;
  logic                   zero_r;
  logic signed [SB-1:0]   fx_r, fy_r;
  logic signed [SB-1:0]   ox, oy;
  logic signed [2*SB-1:0] fsq_x, fsq_y, osq_x, osq_y;
  logic [2*SB-2:0]        fsq_x_r, fsq_y_r, osq_x_r, osq_y_r;

  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [SUM_W-1:0]        sum_x_u, sum_y_u, mag_x, mag_y;
  logic [SQ_W-1:0]         sq_x_r, sq_y_r, sq_x_nxt, sq_y_nxt;

  // Read-before-write on the same slot returns the sample that leaves the window.
  always_ff @(posedge clk) begin
    if (take) begin
      old_r            <= win_mem[ptr_r];
      win_mem[ptr_r]   <= {accel_x, accel_y};
      fx_r             <= accel_x;
      fy_r             <= accel_y;
      zero_r           <= !filled_r;
    end
  end

  // Until the pointer has wrapped once, the leaving sample is the initial zero.
  assign ox = zero_r ? '0 : $signed(old_r[2*SB-1:SB]);
  assign oy = zero_r ? '0 : $signed(old_r[SB-1:0]);

  assign fsq_x = (2*SB)'(fx_r) * (2*SB)'(fx_r);
  assign fsq_y = (2*SB)'(fy_r) * (2*SB)'(fy_r);
  assign osq_x = (2*SB)'(ox) * (2*SB)'(ox);
  assign osq_y = (2*SB)'(oy) * (2*SB)'(oy);

  always_ff @(posedge clk) begin
    if (f1_v_r) begin
      fsq_x_r <= fsq_x[2*SB-2:0];
      fsq_y_r <= fsq_y[2*SB-2:0];
      osq_x_r <= osq_x[2*SB-2:0];
      osq_y_r <= osq_y[2*SB-2:0];
    end
  end

  assign sq_x_nxt = sq_x_r + SQ_W'(fsq_x_r) - SQ_W'(osq_x_r);
  assign sq_y_nxt = sq_y_r + SQ_W'(fsq_y_r) - SQ_W'(osq_y_r);

  assign sum_x_u = sum_x_r;
  assign sum_y_u = sum_y_r;
  assign mag_x   = sum_x_u[SUM_W-1] ? ('0 - sum_x_u) : sum_x_u;
  assign mag_y   = sum_y_u[SUM_W-1] ? ('0 - sum_y_u) : sum_y_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      filled_r <= 1'b0;
      f1_v_r   <= 1'b0;
      f2_v_r   <= 1'b0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sq_x_r   <= '0;
      sq_y_r   <= '0;
    end else begin
      f1_v_r <= take;
      f2_v_r <= f1_v_r;
      if (take) begin
        if (ptr_r == PTR_W'(WINDOW - 1)) begin
          ptr_r    <= '0;
          filled_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (f1_v_r) begin
        sum_x_r <= sum_x_r + SUM_W'(fx_r) - SUM_W'(ox);
        sum_y_r <= sum_y_r + SUM_W'(fy_r) - SUM_W'(oy);
      end
      if (f2_v_r) begin
        sq_x_r <= sq_x_nxt;
        sq_y_r <= sq_y_nxt;
      end
    end
  end

  // During the second stage the sum registers already hold this item's sums.
  assign push      = f2_v_r;
  assign push_data = {mag_x, sq_x_nxt, mag_y, sq_y_nxt};
  assign busy      = {f1_v_r, f2_v_r};

endmodule

@@ design/mvsd_back.sv @@
// Back end: scaled variances, threshold compare, hysteresis and result register.
// Depends on mvsd_pkg; drains the queue filled by the front end.
module mvsd_back #(
  parameter int WINDOW = 64,
  parameter int SUM_W  = 22,
  parameter int SQ_W   = 37
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mvsd_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  logic [2*(SUM_W+SQ_W)-1:0]   q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_flying,
  output logic                        out_above
);

  import mvsd_pkg::*;

  localparam int WB      = $clog2(WINDOW + 1);
  localparam int WSQ_W   = SQ_W + WB;
  localparam int H       = (SUM_W + 1) / 2;
  localparam int HI_W    = SUM_W - H;
  localparam int LANE_W  = SUM_W + SQ_W;
  localparam int TOT_W   = WSQ_W + 1;
  localparam int LIM_K   = 2 * WINDOW * WINDOW;
  localparam int LIM_W   = THR_W + $clog2(LIM_K + 1);
  localparam int CMP_W   = (TOT_W > LIM_W) ? TOT_W : LIM_W;

  logic                 adv;
  logic                 b1_v_r, b2_v_r, b3_v_r, out_valid_r;

  logic [SUM_W-1:0]     mag    [2];
  logic [SQ_W-1:0]      sq     [2];
  logic [H-1:0]         lo     [2];
  logic [HI_W-1:0]      hi     [2];
  logic [2*H-1:0]       pll    [2];
  logic [SUM_W-1:0]     phl    [2];
  logic [2*HI_W-1:0]    phh    [2];
  logic [WSQ_W-1:0]     wsq    [2];

  logic [2*H-1:0]       pll_r  [2];
  logic [SUM_W-1:0]     phl_r  [2];
  logic [2*HI_W-1:0]    phh_r  [2];
  logic [WSQ_W-1:0]     wsq_r  [2];
  logic [WSQ_W-1:0]     wsq2_r [2];
  logic [WSQ_W-1:0]     mag2_r [2];
  logic [WSQ_W-1:0]     var_r  [2];

  logic [LIM_W-1:0]     limit_r;
  logic [TOT_W-1:0]     total;
  logic                 above;
  logic                 above_r;

  logic [HYST_W-1:0]    hc;
  logic [RUN_W-1:0]     fly_run_r, fly_run_nxt;
  logic [RUN_W-1:0]     stand_run_r, stand_run_nxt;
  logic                 flying_r, flying_nxt;

  function automatic logic [RUN_W-1:0] run_next(input logic [RUN_W-1:0] cnt,
                                                input logic [HYST_W-1:0] lim);
    logic [RUN_W-1:0] lim_w;
    lim_w = {1'b0, lim};
    if (cnt <= lim_w) begin
      run_next = cnt + 1'b1;
    end else begin
      run_next = lim_w + 1'b1;
    end
  endfunction

  // The whole back pipeline moves together whenever the result register can take.
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;
  assign hc    = cfg.hysteresis_count;

  // The magnitude is squared from two halves, so each multiplier is about half the width of the magnitude.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag[a] = q_data[(1 - a) * LANE_W + SQ_W +: SUM_W];
      sq[a]  = q_data[(1 - a) * LANE_W +: SQ_W];
      lo[a]  = mag[a][H-1:0];
      hi[a]  = mag[a][SUM_W-1:H];
      pll[a] = (2*H)'(lo[a]) * (2*H)'(lo[a]);
      phl[a] = SUM_W'(hi[a]) * SUM_W'(lo[a]);
      phh[a] = (2*HI_W)'(hi[a]) * (2*HI_W)'(hi[a]);
      wsq[a] = WSQ_W'(sq[a]) * WSQ_W'(WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= LIM_W'(cfg.motion_threshold) * LIM_W'(LIM_K);
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        pll_r[a]  <= pll[a];
        phl_r[a]  <= phl[a];
        phh_r[a]  <= phh[a];
        wsq_r[a]  <= wsq[a];
        mag2_r[a] <= (WSQ_W'(phh_r[a]) << (2 * H)) + (WSQ_W'(phl_r[a]) << (H + 1))
                     + WSQ_W'(pll_r[a]);
        wsq2_r[a] <= wsq_r[a];
        var_r[a]  <= wsq2_r[a] - mag2_r[a];
      end
      if (b3_v_r) begin
        above_r <= above;
      end
    end
  end

  assign total = TOT_W'(var_r[0]) + TOT_W'(var_r[1]);
  assign above = CMP_W'(total) > CMP_W'(limit_r);

  always_comb begin
    fly_run_nxt   = fly_run_r;
    stand_run_nxt = stand_run_r;
    flying_nxt    = flying_r;
    if (above) begin
      stand_run_nxt = '0;
      fly_run_nxt   = run_next(fly_run_r, hc);
      if (fly_run_r == {1'b0, hc}) begin
        flying_nxt = 1'b1;
      end
    end else begin
      fly_run_nxt   = '0;
      stand_run_nxt = run_next(stand_run_r, hc);
      if (stand_run_r == {1'b0, hc}) begin
        flying_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      b3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fly_run_r   <= '0;
      stand_run_r <= '0;
      flying_r    <= 1'b0;
    end else if (adv) begin
      b1_v_r      <= q_valid;
      b2_v_r      <= b1_v_r;
      b3_v_r      <= b2_v_r;
      out_valid_r <= b3_v_r;
      if (b3_v_r) begin
        fly_run_r   <= fly_run_nxt;
        stand_run_r <= stand_run_nxt;
        flying_r    <= flying_nxt;
      end
    end
  end

  // The flag only changes when a result is loaded, so it doubles as the result field.
  assign out_valid  = out_valid_r;
  assign out_flying = flying_r;
  assign out_above  = above_r;

endmodule

@@ design/motion_variance_state_detector.sv @@
// Motion variance state detector: takes one X/Y accelerometer sample per transfer and returns
// one result per sample, the flying flag and whether the mean per-axis variance over the last
// WINDOW samples exceeded motion_threshold. A new sample is taken every cycle while the output
// is not stalled; a result passes the front-end registers, the queue and the back-end stages,
// and is held in the result register until taken. The rate is set by the window
// memory, which does one read and one write of the same slot per sample; the running sums and
// the variance pipeline behind it keep pace. The window starts as all zeros without a clearing
// pass: a flag marks when every slot has been written once. Registers (byte addresses 0 and 4):
// motion_threshold and hysteresis_count; write them only while no sample is in flight.
module motion_variance_state_detector #(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mvsd_in_if.sink                       in_chan,
  mvsd_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mvsd_pkg::APB_AW-1:0]   paddr,
  input  logic [mvsd_pkg::APB_DW-1:0]   pwdata,
  output logic [mvsd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  import mvsd_pkg::*;

  localparam int CLOG_W  = $clog2(WINDOW);
  localparam int SUM_W   = SAMPLE_BITS + CLOG_W;
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1 + CLOG_W;
  localparam int ENTRY_W = 2 * (SUM_W + SQ_W);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W   = CNT_W + 1;

  logic [THR_W-1:0]   thr_r;
  logic [HYST_W-1:0]  hyst_r;
  cfg_t               cfg;
  reg_idx_t           reg_idx;

  logic               take;
  logic [1:0]         front_busy;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic [ENTRY_W-1:0] pop_data;
  logic               q_not_empty;
  logic [CNT_W-1:0]   q_count;
  logic [OCC_W-1:0]   occupancy;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      hyst_r <= HYST_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MOTION_THRESHOLD: thr_r  <= pwdata[THR_W-1:0];
        REG_HYSTERESIS_COUNT: hyst_r <= pwdata[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MOTION_THRESHOLD: prdata = APB_DW'(thr_r);
      REG_HYSTERESIS_COUNT: prdata = APB_DW'(hyst_r);
      default:              prdata = '0;
    endcase
  end

  assign cfg.motion_threshold = thr_r;
  assign cfg.hysteresis_count = hyst_r;

  // Items in the front stages already own a queue slot, so the front never stalls.
  assign occupancy = OCC_W'(q_count) + OCC_W'(front_busy[1]) + OCC_W'(front_busy[0]);
  assign in_chan.ready = (occupancy < OCC_W'(QUEUE_DEPTH));
  assign take = in_chan.valid && in_chan.ready;

  mvsd_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .SQ_W        (SQ_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .accel_x   (in_chan.accel_x),
    .accel_y   (in_chan.accel_y),
    .busy      (front_busy),
    .push      (push),
    .push_data (push_data)
  );

  mvsd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  mvsd_back #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .SQ_W   (SQ_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_not_empty),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_flying (out_chan.flying),
    .out_above  (out_chan.above_threshold)
  );

endmodule

@@ design/mvsd_checker.sv @@
// Port-level checker for the motion variance state detector, with its bind.
// Depends on motion_variance_state_detector_assert.svh and the top level.
`include "motion_variance_state_detector_assert.svh"

module mvsd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_flying,
  input logic out_above
);

  logic [4:0] outstanding_r;
  logic       last_fly_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Samples taken whose result has not yet been transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
      last_fly_r    <= 1'b0;
    end else begin
      if (in_xfer && !out_xfer) begin
        outstanding_r <= outstanding_r + 1'b1;
      end else if (out_xfer && !in_xfer) begin
        outstanding_r <= outstanding_r - 1'b1;
      end
      if (out_xfer) begin
        last_fly_r <= out_flying;
      end
    end
  end

  `MVSD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `MVSD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_flying) && $stable(out_above))
  `MVSD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)
  `MVSD_ASSERT_IMP(a_no_invented, clk, rst_n, out_valid, outstanding_r != '0)
  `MVSD_ASSERT_IMP(a_flag_follows, clk, rst_n, out_xfer && (out_flying != last_fly_r), out_above == out_flying)

endmodule

bind motion_variance_state_detector mvsd_checker u_mvsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_flying (out_chan.flying),
  .out_above  (out_chan.above_threshold)
);
